/* rtl/ibl_pkg.sv */
`default_nettype none

package ibl_pkg;

  // item kinds
  typedef enum logic [2:0] {
    KIND_WR_SRC = 3'd0,
    KIND_WR_DST = 3'd1,
    KIND_RD_DST = 3'd2,
    KIND_PASTE  = 3'd3,
    KIND_FILL   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_e;

  localparam logic [8:0] SIZE_RESET = 9'd256;
  localparam logic [7:0] PIX_ZERO   = 8'd0;

  // controller state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic run;
  } ibl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rect;
    logic empty;
    logic last;
  } ibl_stat_t;

  // size register saturated to the image maximum
  function automatic logic [8:0] clamp_size(input logic [8:0] v, input int lim);
    logic [8:0] r;
    if (int'(v) > lim) begin
      r = lim[8:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [8:0] umin9(input logic [8:0] a, input logic [8:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

/* rtl/ibl_ctrl.sv */
`default_nettype none

module ibl_ctrl import ibl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire ibl_stat_t stat,
  output logic           busy,
  output logic           done,
  output ibl_cmd_t       cmd
);

  state_e state, state_next;
  logic   done_next;

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.rect) begin
            state_next = ST_SETUP;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.empty) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        if (stat.last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/ibl_datapath.sv */
`default_nettype none

module ibl_datapath import ibl_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ibl_cmd_t   cmd,
  output ibl_stat_t       stat,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] x_pos,
  input  wire logic [7:0] y_pos,
  input  wire logic [8:0] rect_width,
  input  wire logic [8:0] rect_height,
  input  wire logic [7:0] dest_x,
  input  wire logic [7:0] dest_y,
  input  wire logic       transparent,
  input  wire logic [7:0] value,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output logic [7:0]      read_pixel,
  output logic            status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] src_mem [DEPTH];
  logic [7:0] dst_mem [DEPTH];

  // configuration registers
  logic [8:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_reg <= SIZE_RESET;
      src_h_reg <= SIZE_RESET;
      dst_w_reg <= SIZE_RESET;
      dst_h_reg <= SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SRC_W: src_w_reg <= cfg_data;
        REG_SRC_H: src_h_reg <= cfg_data;
        REG_DST_W: dst_w_reg <= cfg_data;
        REG_DST_H: dst_h_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [8:0] sw, sh, dw, dh;
  assign sw = clamp_size(src_w_reg, MAX_WIDTH);
  assign sh = clamp_size(src_h_reg, MAX_HEIGHT);
  assign dw = clamp_size(dst_w_reg, MAX_WIDTH);
  assign dh = clamp_size(dst_h_reg, MAX_HEIGHT);

  // single pixel requests, straight from the ports
  logic          src_in, dst_in;
  logic [AW-1:0] pix_addr;

  assign src_in   = ({1'b0, x_pos} < sw) && ({1'b0, y_pos} < sh);
  assign dst_in   = ({1'b0, x_pos} < dw) && ({1'b0, y_pos} < dh);
  assign pix_addr = AW'(32'(y_pos) * MAX_WIDTH + 32'(x_pos));

  assign stat.rect = (kind inside {KIND_PASTE, KIND_FILL, KIND_CLEAR});

  // latched request fields for rectangle work
  logic [2:0] kind_q;
  logic [7:0] xp_q, yp_q, dx_q, dy_q, val_q;
  logic [8:0] rw_q, rh_q;
  logic       transp_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q   <= kind;
      xp_q     <= x_pos;
      yp_q     <= y_pos;
      rw_q     <= rect_width;
      rh_q     <= rect_height;
      dx_q     <= dest_x;
      dy_q     <= dest_y;
      transp_q <= transparent;
      val_q    <= value;
    end
  end

  // result registers
  logic is_read_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= 1'b0;
      is_read_q <= 1'b0;
    end else if (cmd.load) begin
      is_read_q <= 1'b0;
      status    <= 1'b0;
      case (kind)
        KIND_WR_SRC: status <= !src_in;
        KIND_WR_DST: status <= !dst_in;
        KIND_RD_DST: begin
          status    <= !dst_in;
          is_read_q <= dst_in;
        end
        default: ;
      endcase
    end
  end

  // clipping of the latched rectangle
  logic [8:0] xp9, yp9, dx9, dy9;
  logic [8:0] cw, ch, sx, sy, ox, oy;
  logic       origin_ok;

  assign xp9 = {1'b0, xp_q};
  assign yp9 = {1'b0, yp_q};
  assign dx9 = {1'b0, dx_q};
  assign dy9 = {1'b0, dy_q};

  always_comb begin
    origin_ok = 1'b0;
    cw = '0;
    ch = '0;
    sx = xp9;
    sy = yp9;
    ox = xp9;
    oy = yp9;
    case (kind_q)
      KIND_PASTE: begin
        origin_ok = (xp9 < sw) && (yp9 < sh) && (dx9 < dw) && (dy9 < dh);
        cw = umin9(rw_q, umin9(sw - xp9, dw - dx9));
        ch = umin9(rh_q, umin9(sh - yp9, dh - dy9));
        ox = dx9;
        oy = dy9;
      end
      KIND_FILL: begin
        origin_ok = (xp9 < dw) && (yp9 < dh);
        cw = umin9(rw_q, dw - xp9);
        ch = umin9(rh_q, dh - yp9);
      end
      KIND_CLEAR: begin
        origin_ok = 1'b1;
        cw = dw;
        ch = dh;
        ox = '0;
        oy = '0;
      end
      default: ;
    endcase
  end

  assign stat.empty = !origin_ok || (cw == '0) || (ch == '0);

  // rectangle walk: column and row counters with row base addresses
  logic [8:0]    w_q, h_q, col, row;
  logic [AW-1:0] src_row, dst_row;
  logic          last_col, last_row;

  assign last_col  = (col == w_q - 9'd1);
  assign last_row  = (row == h_q - 9'd1);
  assign stat.last = last_col && last_row;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      w_q     <= cw;
      h_q     <= ch;
      col     <= '0;
      row     <= '0;
      src_row <= AW'(32'(sy) * MAX_WIDTH + 32'(sx));
      dst_row <= AW'(32'(oy) * MAX_WIDTH + 32'(ox));
    end else if (cmd.run) begin
      if (last_col) begin
        col     <= '0;
        row     <= row + 9'd1;
        src_row <= src_row + AW'(MAX_WIDTH);
        dst_row <= dst_row + AW'(MAX_WIDTH);
      end else begin
        col <= col + 9'd1;
      end
    end
  end

  logic [AW-1:0] run_src_addr, run_dst_addr;
  logic          paste_q;

  assign run_src_addr = src_row + AW'(col);
  assign run_dst_addr = dst_row + AW'(col);
  assign paste_q      = (kind_q == KIND_PASTE);

  // paste write stage in the cycle after the source read
  logic          pw_valid;
  logic [AW-1:0] pw_addr;
  logic [7:0]    src_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_valid <= 1'b0;
    end else begin
      pw_valid <= cmd.run && paste_q;
    end
  end

  always_ff @(posedge clk) begin
    pw_addr <= run_dst_addr;
  end

  // source memory
  logic src_we;
  assign src_we = cmd.load && (kind == KIND_WR_SRC) && src_in;

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[pix_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    src_rdata <= src_mem[run_src_addr];
  end

  // destination write port select
  logic          dst_we;
  logic [AW-1:0] dst_waddr;
  logic [7:0]    dst_wdata;

  always_comb begin
    dst_we    = 1'b0;
    dst_waddr = pix_addr;
    dst_wdata = value;
    if (pw_valid) begin
      dst_we    = !(transp_q && (src_rdata == PIX_ZERO));
      dst_waddr = pw_addr;
      dst_wdata = src_rdata;
    end else if (cmd.run && !paste_q) begin
      dst_we    = 1'b1;
      dst_waddr = run_dst_addr;
      dst_wdata = val_q;
    end else if (cmd.load && (kind == KIND_WR_DST) && dst_in) begin
      dst_we = 1'b1;
    end
  end

  // destination memory
  logic [7:0] dst_rdata;

  always_ff @(posedge clk) begin
    if (dst_we) begin
      dst_mem[dst_waddr] <= dst_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dst_rdata <= dst_mem[pix_addr];
    end
  end

  assign read_pixel = is_read_q ? dst_rdata : PIX_ZERO;

endmodule

`default_nettype wire

/* rtl/indexed_image_blitter_top.sv */
`default_nettype none

// Indexed-image blitter over a source and a destination image of 8-bit pixels.
// Request channel: a request is taken at a clock edge with start high and busy
// low; kind selects write source pixel, write dest pixel, read dest pixel,
// paste, fill or clear. Each request gives exactly one result: done is high
// for one cycle with read_pixel and status valid in that same cycle.
// Single pixel requests (and unused kinds) keep busy low: one request per
// cycle, result in the cycle after the request. Reads use the registered
// destination memory port.
// Paste, fill and clear raise busy through a setup state that clips the
// rectangle to the images (for clear the destination size), a run state that
// moves one pixel per cycle through the memory ports, and a flush state that
// drains the paste write stage. An empty rectangle goes from setup straight
// back to idle. The result strobe comes in the first cycle with busy low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// four size registers; cfg_ready is always high. Write only while idle.
// Reset sets all sizes to 256 and returns to idle; image memories are not
// cleared. The receiver cannot stall results, so none are ever held.
module indexed_image_blitter_top import ibl_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] x_pos,
  input  wire logic [7:0] y_pos,
  input  wire logic [8:0] rect_width,
  input  wire logic [8:0] rect_height,
  input  wire logic [7:0] dest_x,
  input  wire logic [7:0] dest_y,
  input  wire logic       transparent,
  input  wire logic [7:0] value,
  output logic            done,
  output logic [7:0]      read_pixel,
  output logic            status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  ibl_cmd_t  cmd;
  ibl_stat_t stat;

  assign cfg_ready = 1'b1;

  ibl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ibl_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (kind),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .transparent (transparent),
    .value       (value),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .read_pixel  (read_pixel),
    .status      (status)
  );

  // no result strobe while a rectangle is in progress
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe while busy");

  // a single pixel request answers in the next cycle
  a_pixel_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != KIND_PASTE && kind != KIND_FILL && kind != KIND_CLEAR)
      |=> done)
    else $error("single pixel request without result");

  // a refused access never returns pixel data
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_pixel == PIX_ZERO))
    else $error("refused access returned pixel data");

endmodule

`default_nettype wire
